>>> hw/rtl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared widths, command codes, state encoding and task row layout for the
// earliest-deadline-first tick scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int CMD_W      = 2;
    localparam int IDX_IN_W   = 3;
    localparam int BUDGET_W   = 16;
    localparam int PERIOD_W   = 16;
    localparam int DEADLINE_W = 16;
    localparam int TIME_W     = 32;
    localparam int RUN_W      = 4;
    localparam int COUNT_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESTART,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [BUDGET_W-1:0]   budget;
        logic [PERIOD_W-1:0]   period;
        logic [DEADLINE_W-1:0] deadline;
        logic [BUDGET_W-1:0]   remaining;
        logic [TIME_W-1:0]     arrival;
    } task_row_t;

endpackage

>>> hw/rtl/edf_req_if.sv
// ----------------------------------------------------------------------------
// edf_req_if
// Command channel: tick, task entry write and restart transactions.
// ----------------------------------------------------------------------------
interface edf_req_if;

    logic                            valid;
    logic                            ready;
    logic [edf_pkg::CMD_W-1:0]       cmd;
    logic [edf_pkg::IDX_IN_W-1:0]    task_index;
    logic [edf_pkg::BUDGET_W-1:0]    exec_budget;
    logic [edf_pkg::PERIOD_W-1:0]    task_period;
    logic [edf_pkg::DEADLINE_W-1:0]  rel_deadline;

    modport source (
        output valid, cmd, task_index, exec_budget, task_period, rel_deadline,
        input  ready
    );

    modport sink (
        input  valid, cmd, task_index, exec_budget, task_period, rel_deadline,
        output ready
    );

endinterface

>>> hw/rtl/edf_rsp_if.sv
// ----------------------------------------------------------------------------
// edf_rsp_if
// Result channel: one transaction per scheduled tick.
// ----------------------------------------------------------------------------
interface edf_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [edf_pkg::RUN_W-1:0]    running_task;
    logic                         job_done;
    logic [edf_pkg::TIME_W-1:0]   tick_time;

    modport source (
        output valid, running_task, job_done, tick_time,
        input  ready
    );

    modport sink (
        input  valid, running_task, job_done, tick_time,
        output ready
    );

endinterface

>>> hw/rtl/edf_cfg_if.sv
// ----------------------------------------------------------------------------
// edf_cfg_if
// Configuration write channel for the task_count register.
// ----------------------------------------------------------------------------
interface edf_cfg_if;

    logic                          valid;
    logic                          ready;
    logic [edf_pkg::COUNT_W-1:0]   task_count;

    modport source (
        output valid, task_count,
        input  ready
    );

    modport sink (
        input  valid, task_count,
        output ready
    );

endinterface

>>> hw/rtl/edf_tick_scheduler_unit.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler_unit
// Tick: scans limit = min(task_count, NUM_TASKS) rows, reading one task row per cycle
// from the table's read port, then updates the picked row, if any, in the finish state.
// Restart: all NUM_TASKS rows, one row rewound per cycle. Write: handled in idle.
// Each tick gives one result transaction, loaded in the finish state.
// Reset clears time, task_count and control; the task table is not cleared.
// ----------------------------------------------------------------------------
module edf_tick_scheduler_unit #(
    parameter int NUM_TASKS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    edf_req_if.sink         req,
    edf_rsp_if.source       rsp,
    edf_cfg_if.sink         cfg
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int TW    = edf_pkg::TIME_W;
    localparam int RW    = edf_pkg::RUN_W;

    // task table, one row per task
    edf_pkg::task_row_t mem [NUM_TASKS];
    edf_pkg::task_row_t rd_row_reg;

    edf_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               found_reg, found_next;
    logic [TW-1:0]      best_dl_reg, best_dl_next;
    edf_pkg::task_row_t best_row_reg, best_row_next;
    logic [IDX_W-1:0]   pick_reg, pick_next;
    logic [TW-1:0]      time_reg, time_next;
    logic [edf_pkg::COUNT_W-1:0] task_count_reg;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [RW-1:0]      rsp_run_reg, rsp_run_next;
    logic               rsp_done_reg, rsp_done_next;
    logic [TW-1:0]      rsp_time_reg, rsp_time_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    edf_pkg::task_row_t wr_row;
    logic               rd_en;
    logic               req_ready;

    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   scan_end;
    logic               issue;
    logic [TW-1:0]      abs_dl;
    logic               eligible;
    edf_pkg::task_row_t upd_row;
    logic               job_done_w;
    logic [edf_pkg::BUDGET_W-1:0] rem_dec;
    logic               idx_ok;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            task_count_reg <= cfg.task_count;
        end
    end

    always_comb
    begin
        if (int'(task_count_reg) > NUM_TASKS)
        begin
            limit = CNT_W'(NUM_TASKS);
        end
        else
        begin
            limit = CNT_W'(task_count_reg);
        end
    end

    // ------------------------------------------------------------------------
    // task table memory
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------------
    assign scan_end = (state_reg == edf_pkg::ST_RESTART) ? CNT_W'(NUM_TASKS) : limit;
    assign issue    = scan_idx_reg < scan_end;
    assign idx_ok   = int'(req.task_index) < NUM_TASKS;

    assign abs_dl   = rd_row_reg.arrival + TW'(rd_row_reg.deadline);
    assign eligible = (time_reg >= rd_row_reg.arrival) && (rd_row_reg.remaining != '0);

    always_comb
    begin
        rem_dec    = best_row_reg.remaining - edf_pkg::BUDGET_W'(1);
        job_done_w = (rem_dec == '0);
        upd_row    = best_row_reg;
        if (job_done_w)
        begin
            upd_row.remaining = best_row_reg.budget;
            upd_row.arrival   = best_row_reg.arrival + TW'(best_row_reg.period);
        end
        else
        begin
            upd_row.remaining = rem_dec;
        end
    end

    // ------------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edf_pkg::ST_IDLE;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            time_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            time_reg      <= time_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        best_dl_reg  <= best_dl_next;
        best_row_reg <= best_row_next;
        pick_reg     <= pick_next;
        rsp_run_reg  <= rsp_run_next;
        rsp_done_reg <= rsp_done_next;
        rsp_time_reg <= rsp_time_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        best_dl_next   = best_dl_reg;
        best_row_next  = best_row_reg;
        pick_next      = pick_reg;
        time_next      = time_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_run_next   = rsp_run_reg;
        rsp_done_next  = rsp_done_reg;
        rsp_time_next  = rsp_time_reg;
        wr_en          = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_row         = rd_row_reg;
        rd_en          = 1'b0;
        req_ready      = 1'b0;

        case (state_reg)
            edf_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    case (req.cmd)
                        edf_pkg::CMD_TICK:
                        begin
                            scan_idx_next = '0;
                            found_next    = 1'b0;
                            state_next    = edf_pkg::ST_SCAN;
                        end
                        edf_pkg::CMD_WRITE:
                        begin
                            if (idx_ok)
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = IDX_W'(req.task_index);
                                wr_row.budget    = req.exec_budget;
                                wr_row.period    = req.task_period;
                                wr_row.deadline  = req.rel_deadline;
                                wr_row.remaining = req.exec_budget;
                                wr_row.arrival   = '0;
                            end
                        end
                        edf_pkg::CMD_RESTART:
                        begin
                            time_next     = '0;
                            scan_idx_next = '0;
                            state_next    = edf_pkg::ST_RESTART;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            edf_pkg::ST_RESTART:
            begin
                // read row k while row k-1 is written back rewound
                rd_en          = issue;
                chk_valid_next = issue;
                chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (chk_valid_reg)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = chk_idx_reg;
                    wr_row.remaining = rd_row_reg.budget;
                    wr_row.arrival   = '0;
                end
                if (!issue)
                begin
                    state_next = edf_pkg::ST_IDLE;
                end
            end

            edf_pkg::ST_SCAN:
            begin
                rd_en          = issue;
                chk_valid_next = issue;
                chk_idx_next   = scan_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                // strict compare keeps the lower index on ties
                if (chk_valid_reg && eligible && (!found_reg || (abs_dl < best_dl_reg)))
                begin
                    found_next    = 1'b1;
                    best_dl_next  = abs_dl;
                    best_row_next = rd_row_reg;
                    pick_next     = chk_idx_reg;
                end
                if (!issue)
                begin
                    state_next = edf_pkg::ST_FINISH;
                end
            end

            edf_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_run_next   = found_reg ?
                                     RW'({1'b0, pick_reg} + (IDX_W + 1)'(1)) : '0;
                    rsp_done_next  = found_reg && job_done_w;
                    rsp_time_next  = time_reg;
                    time_next      = time_reg + TW'(1);
                    wr_en          = found_reg;
                    wr_addr        = pick_reg;
                    wr_row         = upd_row;
                    state_next     = edf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = edf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------------
    assign req.ready        = req_ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.running_task = rsp_run_reg;
    assign rsp.job_done     = rsp_done_reg;
    assign rsp.tick_time    = rsp_time_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_no_write_in_scan : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == edf_pkg::ST_SCAN) |-> !wr_en
    ) else $error("task table written during scan");

    a_result_from_finish : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == edf_pkg::ST_FINISH)
    ) else $error("result loaded outside finish");

    a_time_advance : assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == edf_pkg::ST_FINISH) && (!rsp_valid_reg || rsp.ready))
        |=> (time_reg == $past(time_reg) + TW'(1))
    ) else $error("time did not advance after tick");

    a_pick_in_range : assert property (
        @(posedge clk) disable iff (!rst_n)
        ((state_reg == edf_pkg::ST_FINISH) && found_reg) |-> (CNT_W'(pick_reg) < limit)
    ) else $error("picked task beyond task_count");

    a_done_has_task : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_done_reg) |-> (rsp_run_reg != '0)
    ) else $error("job done reported on idle tick");

endmodule

>>> bench/tb_edf_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edf_tick_scheduler_unit
// Self-checking bench for the EDF tick scheduler. A directed task set comes
// first. Randomized phases of task writes, restarts, ticks and unused opcodes
// follow, with random gaps on both channels. Every tick result is compared
// with an in-bench schedule model.
// ----------------------------------------------------------------------------
module tb_edf_tick_scheduler_unit;

    localparam int TASK_SLOTS  = 8;
    localparam int SETTLE_CYC  = TASK_SLOTS + 8;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 55;
    localparam logic [edf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [edf_pkg::CMD_W-1:0]      cmd;
        logic [edf_pkg::IDX_IN_W-1:0]   task_index;
        logic [edf_pkg::BUDGET_W-1:0]   exec_budget;
        logic [edf_pkg::PERIOD_W-1:0]   task_period;
        logic [edf_pkg::DEADLINE_W-1:0] rel_deadline;
    } sched_cmd_t;

    typedef struct packed {
        logic [edf_pkg::RUN_W-1:0]  running_task;
        logic                       job_done;
        logic [edf_pkg::TIME_W-1:0] tick_time;
    } tick_result_t;

    class edf_schedule_board;
        bit [edf_pkg::BUDGET_W-1:0]   budget    [TASK_SLOTS];
        bit [edf_pkg::PERIOD_W-1:0]   period    [TASK_SLOTS];
        bit [edf_pkg::DEADLINE_W-1:0] deadline  [TASK_SLOTS];
        bit [edf_pkg::BUDGET_W-1:0]   remaining [TASK_SLOTS];
        bit [edf_pkg::TIME_W-1:0]     arrival   [TASK_SLOTS];
        bit [edf_pkg::TIME_W-1:0]     now_time;
        bit [edf_pkg::COUNT_W-1:0]    task_count;
        tick_result_t                 pending_ticks[$];
        int                           errors;
        int                           ticks;
        int                           idle_ticks;
        int                           jobs_done;
        int                           writes;
        int                           restarts;
        int                           ignored;
        int                           results;

        // applies one accepted command and queues the tick outcome, if any
        function void log_command(input sched_cmd_t c);
            tick_result_t             res;
            int                       lim;
            int                       pick;
            bit                       found;
            bit [edf_pkg::TIME_W-1:0] best;
            bit [edf_pkg::TIME_W-1:0] abs_dl;
            case (c.cmd)
                edf_pkg::CMD_WRITE:
                begin
                    budget[c.task_index]    = c.exec_budget;
                    period[c.task_index]    = c.task_period;
                    deadline[c.task_index]  = c.rel_deadline;
                    remaining[c.task_index] = c.exec_budget;
                    arrival[c.task_index]   = '0;
                    writes++;
                end
                edf_pkg::CMD_RESTART:
                begin
                    now_time = '0;
                    for (int k = 0; k < TASK_SLOTS; k++)
                    begin
                        remaining[k] = budget[k];
                        arrival[k]   = '0;
                    end
                    restarts++;
                end
                edf_pkg::CMD_TICK:
                begin
                    lim   = (task_count > TASK_SLOTS) ? TASK_SLOTS : int'(task_count);
                    found = 1'b0;
                    pick  = 0;
                    best  = '0;
                    for (int k = 0; k < lim; k++)
                    begin
                        if (now_time >= arrival[k] && remaining[k] != '0)
                        begin
                            abs_dl = arrival[k] + edf_pkg::TIME_W'(deadline[k]);
                            // strict compare keeps the lower index on a tie
                            if (!found || abs_dl < best)
                            begin
                                found = 1'b1;
                                best  = abs_dl;
                                pick  = k;
                            end
                        end
                    end
                    res.running_task = found ? edf_pkg::RUN_W'(pick + 1) : '0;
                    res.job_done     = 1'b0;
                    res.tick_time    = now_time;
                    if (found)
                    begin
                        remaining[pick] = remaining[pick] - 1'b1;
                        if (remaining[pick] == '0)
                        begin
                            res.job_done    = 1'b1;
                            remaining[pick] = budget[pick];
                            arrival[pick]   = arrival[pick] + edf_pkg::TIME_W'(period[pick]);
                            jobs_done++;
                        end
                    end
                    else
                        idle_ticks++;
                    now_time = now_time + 1'b1;
                    pending_ticks.push_back(res);
                    ticks++;
                end
                default:
                    ignored++;
            endcase
        endfunction

        function void check_tick_result(input logic [edf_pkg::RUN_W-1:0] run_task,
                                        input logic done,
                                        input logic [edf_pkg::TIME_W-1:0] t);
            tick_result_t want;
            if (pending_ticks.size() == 0)
            begin
                $error("unexpected tick result: running_task %0d job_done %0d tick_time %0d",
                       run_task, done, t);
                errors++;
                return;
            end
            want = pending_ticks.pop_front();
            results++;
            if (run_task !== want.running_task)
            begin
                $error("running_task: expected %0d, got %0d", want.running_task, run_task);
                errors++;
            end
            if (done !== want.job_done)
            begin
                $error("job_done: expected %0d, got %0d", want.job_done, done);
                errors++;
            end
            if (t !== want.tick_time)
            begin
                $error("tick_time: expected %0d, got %0d", want.tick_time, t);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    bit                burst_mode  = 1'b0;
    int                idle_cycles = 0;
    int                cfg_writes  = 0;
    edf_schedule_board board;

    edf_req_if req_if ();
    edf_rsp_if rsp_if ();
    edf_cfg_if cfg_if ();

    edf_tick_scheduler_unit #(
        .NUM_TASKS (TASK_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sched_cmd_t make_cmd(input logic [edf_pkg::CMD_W-1:0] op);
        sched_cmd_t c;
        c.cmd          = op;
        c.task_index   = edf_pkg::IDX_IN_W'($urandom);
        c.exec_budget  = edf_pkg::BUDGET_W'($urandom);
        c.task_period  = edf_pkg::PERIOD_W'($urandom);
        c.rel_deadline = edf_pkg::DEADLINE_W'($urandom);
        return c;
    endfunction

    function automatic sched_cmd_t make_write(input int idx, input int b, input int p,
                                              input int d);
        sched_cmd_t c;
        c.cmd          = edf_pkg::CMD_WRITE;
        c.task_index   = edf_pkg::IDX_IN_W'(idx);
        c.exec_budget  = edf_pkg::BUDGET_W'(b);
        c.task_period  = edf_pkg::PERIOD_W'(p);
        c.rel_deadline = edf_pkg::DEADLINE_W'(d);
        return c;
    endfunction

    // mostly short jobs and periods so that jobs finish and arrivals move
    function automatic sched_cmd_t random_write();
        sched_cmd_t c;
        c = make_cmd(edf_pkg::CMD_WRITE);
        case ($urandom_range(0, 15)) inside
            [0:1]:   c.exec_budget = '0;
            2:       c.exec_budget = edf_pkg::BUDGET_W'($urandom);
            default: c.exec_budget = edf_pkg::BUDGET_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 15))
            0:       c.task_period = '0;
            1:       c.task_period = edf_pkg::PERIOD_W'($urandom);
            default: c.task_period = edf_pkg::PERIOD_W'($urandom_range(1, 24));
        endcase
        if ($urandom_range(0, 15) != 0)
            c.rel_deadline = edf_pkg::DEADLINE_W'($urandom_range(0, 30));
        return c;
    endfunction

    task automatic send_command(input sched_cmd_t c);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        = 1'b1;
        req_if.cmd          = c.cmd;
        req_if.task_index   = c.task_index;
        req_if.exec_budget  = c.exec_budget;
        req_if.task_period  = c.task_period;
        req_if.rel_deadline = c.rel_deadline;
        do
        begin
            @(posedge clk);
        end
        while (!req_if.ready);
        board.log_command(c);
    endtask

    // hold off until every tick result is back and the unit has gone quiet
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (board.pending_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_task_count(input logic [edf_pkg::COUNT_W-1:0] value);
        @(negedge clk);
        cfg_if.valid      = 1'b1;
        cfg_if.task_count = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        board.task_count = value;
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // result side: random back-pressure per transaction
    initial
    begin
        int stall;
        rsp_if.ready = 1'b0;
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(rsp_if.valid && rst_n));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            board.check_tick_result(rsp_if.running_task, rsp_if.job_done, rsp_if.tick_time);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        sched_cmd_t c;
        int         pick;
        board               = new();
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.cmd          = edf_pkg::CMD_TICK;
        req_if.task_index   = '0;
        req_if.exec_budget  = '0;
        req_if.task_period  = '0;
        req_if.rel_deadline = '0;
        cfg_if.valid        = 1'b0;
        cfg_if.task_count   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty schedule, ignored opcode, then fill the whole table
        write_task_count('0);
        send_command(make_cmd(edf_pkg::CMD_TICK));
        send_command(make_cmd(CMD_UNUSED));
        send_command(make_write(0, 2, 5, 4));
        send_command(make_write(1, 1, 3, 4));           // ties with entry 0
        send_command(make_write(2, 0, 16'hFFFF, 0));    // zero budget, never runs
        send_command(make_write(3, 16'hFFFF, 1, 16'hFFFF));
        send_command(make_write(4, 1, 0, 16'hFFFF));    // zero period, arrival stays put
        send_command(make_write(5, 3, 10, 0));
        send_command(make_write(6, 2, 7, 20));
        send_command(make_write(7, 1, 4, 9));
        wait_drained();
        write_task_count(4'hF);                         // above table size, saturates
        repeat (8) send_command(make_cmd(edf_pkg::CMD_TICK));
        send_command(make_cmd(edf_pkg::CMD_RESTART));
        wait_drained();
        write_task_count(4'd1);
        // one job then idle ticks until the next arrival
        repeat (4) send_command(make_cmd(edf_pkg::CMD_TICK));

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            burst_mode = ($urandom_range(0, 3) == 0);
            case (ph)
                0:       write_task_count(edf_pkg::COUNT_W'(TASK_SLOTS));
                1:       write_task_count(4'hF);
                default: write_task_count(edf_pkg::COUNT_W'($urandom_range(1, 15)));
            endcase
            repeat ($urandom_range(1, 4)) send_command(random_write());
            if ($urandom_range(0, 1) == 1)
                send_command(make_cmd(edf_pkg::CMD_RESTART));
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 84)
                    c = make_cmd(edf_pkg::CMD_TICK);
                else if (pick < 92)
                    c = random_write();
                else if (pick < 96)
                    c = make_cmd(edf_pkg::CMD_RESTART);
                else
                    c = make_cmd(CMD_UNUSED);
                send_command(c);
            end
        end
        wait_drained();

        $display("covered %0d ticks (%0d idle, %0d jobs finished), %0d task writes, %0d restarts",
                 board.ticks, board.idle_ticks, board.jobs_done, board.writes, board.restarts);
        $display("%0d ignored commands, %0d task_count writes, %0d results checked, %0d errors",
                 board.ignored, cfg_writes, board.results, board.errors);
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> edf_tick_scheduler_unit.f
hw/rtl/edf_pkg.sv
hw/rtl/edf_req_if.sv
hw/rtl/edf_rsp_if.sv
hw/rtl/edf_cfg_if.sv
hw/rtl/edf_tick_scheduler_unit.sv
bench/tb_edf_tick_scheduler_unit.sv
